// File: rtl/core/mprp_pkg.sv
// shared types, constants and crc function of the modbus position reply parser
`default_nettype none
package mprp_pkg;

  localparam logic [3:0]  FrameBytes      = 4'd9;
  localparam logic [3:0]  CrcBytes        = 4'd7;
  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [7:0]  DevAddrReset    = 8'h01;
  localparam int          PaddrWidth      = 3;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_FUNC  = 3'd3,
    ST_CRC   = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_DEVICE_ADDRESS = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  count;
    logic [15:0] crc;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [7:0]  len;
    logic [31:0] data;
    logic [15:0] check;
  } frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mprp_frame_acc.sv
// frame capture: byte counter, header and data capture, running crc-16
`default_nettype none
module mprp_frame_acc (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_en,
  input  wire logic            clear_en,
  input  wire logic [7:0]      rx_byte,
  output mprp_pkg::frame_t     frame
);

  mprp_pkg::frame_t frame_r;
  mprp_pkg::frame_t frame_nxt;
  mprp_pkg::frame_t frame_clr;

  always_comb begin
    frame_clr       = '0;
    frame_clr.crc   = mprp_pkg::CrcInit;
    frame_nxt       = frame_r;
    if (clear_en) begin
      frame_nxt = frame_clr;
    end else if (byte_en && (frame_r.count < mprp_pkg::FrameBytes)) begin
      frame_nxt.count = frame_r.count + 4'd1;
      if (frame_r.count < mprp_pkg::CrcBytes) begin
        frame_nxt.crc = mprp_pkg::crc_byte(frame_r.crc, rx_byte);
      end
      unique case (frame_r.count)
        4'd0: frame_nxt.addr         = rx_byte;
        4'd1: frame_nxt.func         = rx_byte;
        4'd2: frame_nxt.len          = rx_byte;
        4'd3: frame_nxt.data[15:8]   = rx_byte;
        4'd4: frame_nxt.data[7:0]    = rx_byte;
        4'd5: frame_nxt.data[31:24]  = rx_byte;
        4'd6: frame_nxt.data[23:16]  = rx_byte;
        4'd7: frame_nxt.check[15:8]  = rx_byte;
        default: frame_nxt.check[7:0] = rx_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= frame_clr;
    end else begin
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;

endmodule
`default_nettype wire

// File: rtl/core/mprp_check.sv
// frame checks in priority order: length, address, function code, crc
`default_nettype none
module mprp_check (
  input  wire mprp_pkg::frame_t frame,
  input  wire logic [7:0]       dev_addr,
  output mprp_pkg::status_t     status
);

  logic [15:0] crc_expect;

  assign crc_expect = {frame.crc[7:0], frame.crc[15:8]};

  always_comb begin
    if (frame.count < mprp_pkg::FrameBytes) begin
      status = mprp_pkg::ST_SHORT;
    end else if (frame.addr != dev_addr) begin
      status = mprp_pkg::ST_ADDR;
    end else if (frame.func != mprp_pkg::FuncReadHolding) begin
      status = mprp_pkg::ST_FUNC;
    end else if (frame.check != crc_expect) begin
      status = mprp_pkg::ST_CRC;
    end else begin
      status = mprp_pkg::ST_OK;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/modbus_position_reply_parser.sv
// a line-idle beat, once accepted, passes through the input register and then the result register
// throughput: one beat per cycle unless an idle beat is held; a data byte beat never waits on the result side
// an idle beat waits in the input register only while the result register is full and stalled
// reset (rst_n low, synchronous): frame state cleared, crc 0xffff, position 0, address 1
// no result is pending after reset
`default_nettype none
module modbus_position_reply_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_frame_status,
  output logic [7:0]       out_frame_address,
  output logic [7:0]       out_function_code,
  output logic [7:0]       out_byte_count,
  output logic [15:0]      out_received_crc,
  output logic [31:0]      out_position,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [mprp_pkg::PaddrWidth-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              s1_valid_r;
  mprp_pkg::opcode_t s1_op_r;
  logic [7:0]        s1_byte_r;
  logic              s1_adv;
  logic              s1_idle;
  logic              in_fire;
  logic              res_fire;

  logic [7:0]        dev_addr_r;
  logic [31:0]       last_position_r;
  logic [31:0]       position_nxt;

  logic              out_valid_r;
  mprp_pkg::status_t out_status_r;
  logic [7:0]        out_addr_r;
  logic [7:0]        out_func_r;
  logic [7:0]        out_len_r;
  logic [15:0]       out_crc_r;
  logic [31:0]       out_pos_r;

  mprp_pkg::frame_t  frame;
  mprp_pkg::status_t status;
  logic              cfg_wr;
  logic              addr_sel;

  assign s1_idle  = s1_valid_r && (s1_op_r == mprp_pkg::OP_IDLE);
  assign s1_adv   = s1_valid_r && (!s1_idle || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign res_fire = s1_adv && s1_idle;

  mprp_frame_acc u_frame_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (s1_adv && (s1_op_r == mprp_pkg::OP_BYTE)),
    .clear_en (res_fire),
    .rx_byte  (s1_byte_r),
    .frame    (frame)
  );

  mprp_check u_check (
    .frame    (frame),
    .dev_addr (dev_addr_r),
    .status   (status)
  );

  assign position_nxt = (status == mprp_pkg::ST_OK) ? frame.data : last_position_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= mprp_pkg::opcode_t'(in_opcode);
      s1_byte_r <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      last_position_r <= '0;
    end else begin
      if (res_fire) begin
        out_valid_r     <= 1'b1;
        last_position_r <= position_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_status_r <= status;
      out_addr_r   <= frame.addr;
      out_func_r   <= frame.func;
      out_len_r    <= frame.len;
      out_crc_r    <= frame.check;
      out_pos_r    <= position_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_status  = out_status_r;
  assign out_frame_address = out_addr_r;
  assign out_function_code = out_func_r;
  assign out_byte_count    = out_len_r;
  assign out_received_crc  = out_crc_r;
  assign out_position      = out_pos_r;

  // register port
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign addr_sel = (paddr[mprp_pkg::PaddrWidth-1] == mprp_pkg::REG_DEVICE_ADDRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= mprp_pkg::DevAddrReset;
    end else if (cfg_wr && addr_sel) begin
      dev_addr_r <= pwdata[7:0];
    end
  end

  assign prdata = addr_sel ? {24'h000000, dev_addr_r} : 32'h00000000;

`ifndef SYNTHESIS
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    frame.count <= mprp_pkg::FrameBytes)
    else $error("frame byte count beyond nine");

  a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> (frame.count == 4'd0) && (frame.crc == mprp_pkg::CrcInit))
    else $error("frame state not cleared after idle");

  a_ok_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == mprp_pkg::ST_OK) |-> out_pos_r == last_position_r)
    else $error("good frame position not stored");

  a_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_op_r == mprp_pkg::OP_BYTE) |-> in_ready)
    else $error("data byte stalled");
`endif

endmodule
`default_nettype wire

// File: tb/position_reply_checker.sv
// crc helper package and checker that predicts and compares parser reports
`default_nettype none
package modbus_crc_tb_pkg;

  function automatic logic [15:0] modbus_crc16_next(input logic [15:0] crc_in,
                                                    input logic [7:0] data_byte);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data_byte};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

module position_reply_checker
  import mprp_pkg::*;
  import modbus_crc_tb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_frame_status,
  input  wire logic [7:0]  out_frame_address,
  input  wire logic [7:0]  out_function_code,
  input  wire logic [7:0]  out_byte_count,
  input  wire logic [15:0] out_received_crc,
  input  wire logic [31:0] out_position,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending,
  output int               reports_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PaddrWidth-1:0] DevAddrOffset = PaddrWidth'(4 * REG_DEVICE_ADDRESS);

  typedef struct {
    status_t            status;
    logic [7:0]         address;
    logic [7:0]         func;
    logic [7:0]         len;
    logic [15:0]        check;
    logic signed [31:0] position;
  } frame_report_t;

  frame_report_t      frame_report_q[$];
  logic [7:0]         device_addr;
  logic [3:0]         frame_bytes_seen;
  logic [15:0]        frame_crc;
  logic [7:0]         hdr_addr;
  logic [7:0]         hdr_func;
  logic [7:0]         hdr_len;
  logic [31:0]        data_word;
  logic [15:0]        check_word;
  logic signed [31:0] good_position;

  initial begin
    fail_count      = 0;
    pending         = 0;
    reports_checked = 0;
  end

  task automatic clear_frame();
    frame_bytes_seen = '0;
    frame_crc        = CrcInit;
    hdr_addr         = '0;
    hdr_func         = '0;
    hdr_len          = '0;
    data_word        = '0;
    check_word       = '0;
  endtask

  task automatic predict_reply_beat(input logic op, input logic [7:0] b);
    frame_report_t rep;
    if (op == OP_BYTE) begin
      if (frame_bytes_seen < FrameBytes) begin
        if (frame_bytes_seen < CrcBytes) begin
          frame_crc = modbus_crc16_next(frame_crc, b);
        end
        case (frame_bytes_seen)
          4'd0: hdr_addr = b;
          4'd1: hdr_func = b;
          4'd2: hdr_len = b;
          4'd3: data_word[15:8] = b;
          4'd4: data_word[7:0] = b;
          4'd5: data_word[31:24] = b;
          4'd6: data_word[23:16] = b;
          4'd7: check_word[15:8] = b;
          default: check_word[7:0] = b;
        endcase
        frame_bytes_seen = frame_bytes_seen + 4'd1;
      end
    end else begin
      if (frame_bytes_seen < FrameBytes) begin
        rep.status = ST_SHORT;
      end else if (hdr_addr != device_addr) begin
        rep.status = ST_ADDR;
      end else if (hdr_func != FuncReadHolding) begin
        rep.status = ST_FUNC;
      end else if (check_word != {frame_crc[7:0], frame_crc[15:8]}) begin
        rep.status = ST_CRC;
      end else begin
        rep.status = ST_OK;
      end
      if (rep.status == ST_OK) begin
        good_position = data_word;
      end
      rep.address  = hdr_addr;
      rep.func     = hdr_func;
      rep.len      = hdr_len;
      rep.check    = check_word;
      rep.position = good_position;
      frame_report_q.push_back(rep);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    frame_report_t rep;
    if (!rst_n) begin
      frame_report_q.delete();
      device_addr   = DevAddrReset;
      good_position = '0;
      clear_frame();
    end else begin
      if (out_valid && out_ready) begin
        reports_checked++;
        if (frame_report_q.size() == 0) begin
          $error("report beat with no frame pending");
          fail_count++;
        end else begin
          rep = frame_report_q.pop_front();
          if (out_frame_status !== rep.status) begin
            $error("frame_status: expected %0d, got %0d", rep.status, out_frame_status);
            fail_count++;
          end
          if (out_frame_address !== rep.address) begin
            $error("frame_address: expected %0d, got %0d", rep.address, out_frame_address);
            fail_count++;
          end
          if (out_function_code !== rep.func) begin
            $error("function_code: expected %0d, got %0d", rep.func, out_function_code);
            fail_count++;
          end
          if (out_byte_count !== rep.len) begin
            $error("byte_count: expected %0d, got %0d", rep.len, out_byte_count);
            fail_count++;
          end
          if (out_received_crc !== rep.check) begin
            $error("received_crc: expected %0h, got %0h", rep.check, out_received_crc);
            fail_count++;
          end
          if (out_position !== rep.position) begin
            $error("position: expected %0d, got %0d", rep.position, $signed(out_position));
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == DevAddrOffset) begin
        device_addr = pwdata[7:0];
      end
      if (in_valid && in_ready) begin
        predict_reply_beat(in_opcode, in_rx_byte);
      end
    end
    pending = frame_report_q.size();
  end

endmodule
`default_nettype wire

// File: tb/modbus_position_reply_parser_tb.sv
// top of the parser testbench: clock, reset, frame stimulus, config writes and verdict
`default_nettype none
module modbus_position_reply_parser_tb;
  import mprp_pkg::*;
  import modbus_crc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PaddrWidth-1:0] DevAddrOffset = PaddrWidth'(4 * REG_DEVICE_ADDRESS);
  localparam int HoldCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_frame_status;
  logic [7:0]  out_frame_address;
  logic [7:0]  out_function_code;
  logic [7:0]  out_byte_count;
  logic [15:0] out_received_crc;
  logic [31:0] out_position;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int         fail_count;
  int         pending;
  int         reports_checked;
  int         beats_sent = 0;
  int         frames_sent = 0;
  int         settings_used = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  bit         calm = 1'b0;
  logic [7:0] dev_addr = DevAddrReset;

  always #5 clk = ~clk;

  modbus_position_reply_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_frame_address (out_frame_address),
    .out_function_code (out_function_code),
    .out_byte_count    (out_byte_count),
    .out_received_crc  (out_received_crc),
    .out_position      (out_position),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  position_reply_checker u_reply_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_frame_address (out_frame_address),
    .out_function_code (out_function_code),
    .out_byte_count    (out_byte_count),
    .out_received_crc  (out_received_crc),
    .out_position      (out_position),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .pending           (pending),
    .reports_checked   (reports_checked)
  );

  // receiver: random stalls, counted hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic send_beat(input opcode_t op, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    in_opcode  = op;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] len, input logic [31:0] data,
                            input int nbytes, input bit bad_crc);
    logic [7:0]  fb [0:8];
    logic [15:0] crc;
    fb  = '{addr, func, len, data[15:8], data[7:0], data[31:24], data[23:16], 8'h00, 8'h00};
    crc = CrcInit;
    for (int i = 0; i < 7; i++) begin
      crc = modbus_crc16_next(crc, fb[i]);
    end
    fb[7] = crc[7:0];
    fb[8] = crc[15:8];
    if (bad_crc) begin
      fb[7 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < nbytes; i++) begin
      send_beat(OP_BYTE, (i < 9) ? fb[i] : 8'($urandom));
    end
    send_beat(OP_IDLE, 8'($urandom));
    frames_sent++;
  endtask

  task automatic drain_reports();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_device_address(input logic [7:0] a);
    in_valid = 1'b0;
    drain_reports();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = DevAddrOffset;
    pwdata  = {24'($urandom), a};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    dev_addr = a;
    settings_used++;
  endtask

  task automatic random_traffic(input int n_beats);
    int          target;
    int          pick;
    logic [31:0] data;
    logic [7:0]  func;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      data = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: data = 32'h8000_0000;
          1: data = 32'h7FFF_FFFF;
          2: data = 32'hFFFF_FFFF;
          default: data = 32'h0000_0000;
        endcase
      end
      func = 8'($urandom);
      if (func == FuncReadHolding) begin
        func ^= 8'h80;
      end
      if (pick < 55) begin
        send_frame(dev_addr, FuncReadHolding, 8'($urandom), data, 9, 1'b0);
      end else if (pick < 65) begin
        send_frame(dev_addr, FuncReadHolding, 8'($urandom), data, 9, 1'b1);
      end else if (pick < 73) begin
        send_frame(dev_addr ^ 8'($urandom_range(1, 255)), FuncReadHolding,
                   8'($urandom), data, 9, 1'b0);
      end else if (pick < 81) begin
        send_frame(dev_addr, func, 8'($urandom), data, 9, 1'b0);
      end else if (pick < 91) begin
        send_frame(dev_addr, FuncReadHolding, 8'($urandom), data,
                   $urandom_range(0, 8), 1'b0);
      end else if (pick < 96) begin
        send_frame(dev_addr, FuncReadHolding, 8'($urandom), data,
                   $urandom_range(10, 14), 1'b0);
      end else begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), data,
                   $urandom_range(0, 14), 1'($urandom));
      end
    end
  endtask

  initial begin
    int errors;
    int wait_cycles;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // idle with nothing received, good frames at the reset address, short frame
    send_beat(OP_IDLE, 8'hFF);
    send_frame(DevAddrReset, FuncReadHolding, 8'h04, 32'h8000_0000, 9, 1'b0);
    send_frame(DevAddrReset, FuncReadHolding, 8'hFF, 32'h7FFF_FFFF, 10, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3, 1'b0);

    set_device_address(8'h00);
    random_traffic(400);

    set_device_address(8'hFF);
    calm = 1'b1;
    random_traffic(300);
    calm = 1'b0;

    set_device_address(8'($urandom_range(2, 254)));
    hold_requests++;
    repeat (6) send_beat(OP_IDLE, 8'($urandom));
    random_traffic(500);

    set_device_address(DevAddrReset);
    random_traffic(600);

    in_valid = 1'b0;
    for (wait_cycles = 0; pending != 0 && wait_cycles < 5000; wait_cycles++) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    errors = fail_count;
    if (pending != 0) begin
      $error("%0d frame reports never arrived", pending);
      errors++;
    end
    $display("covered %0d beats in %0d frames, %0d reports checked", beats_sent,
             frames_sent, reports_checked);
    $display("over %0d address settings, with a long result hold-off and drain pauses",
             settings_used + 1);
    if (errors == 0) begin
      $display("modbus_position_reply_parser_tb: clean");
    end else begin
      $display("modbus_position_reply_parser_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("modbus_position_reply_parser_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/core/mprp_pkg.sv
rtl/core/mprp_frame_acc.sv
rtl/core/mprp_check.sv
rtl/core/modbus_position_reply_parser.sv
tb/position_reply_checker.sv
tb/modbus_position_reply_parser_tb.sv
